/* rtl/ttbp_pkg.sv */
// shared types, constants and register map of the ternary threshold bit packer
// no dependencies
package ttbp_pkg;

   localparam int WORD_BITS    = 64;
   localparam int MAX_CHANNELS = 4096;
   localparam int SAMPLE_BITS  = 16;

   localparam int POS_BITS   = $clog2(WORD_BITS);
   localparam int INDEX_BITS = $clog2(MAX_CHANNELS);
   localparam int COUNT_BITS = 13;
   localparam int THR_BITS   = 15;
   localparam int MODE_BITS  = 2;
   localparam int ADDR_BITS  = 4;
   localparam int DATA_BITS  = 32;

   localparam logic [COUNT_BITS-1:0] COUNT_RESET = COUNT_BITS'(64);
   localparam logic [COUNT_BITS-1:0] COUNT_MAX   = COUNT_BITS'(MAX_CHANNELS);

   typedef enum logic [MODE_BITS-1:0] {
      MODE_SIGN_MAG  = 2'd0,
      MODE_SIGN_ZERO = 2'd1,
      MODE_BINARY    = 2'd2,
      MODE_SPARE     = 2'd3
   } mode_type;

   typedef enum logic [1:0] {
      REG_THRESHOLD     = 2'd0,
      REG_PACK_MODE     = 2'd1,
      REG_CHANNEL_COUNT = 2'd2,
      REG_NONE          = 2'd3
   } reg_index_type;

   typedef struct packed {
      logic [THR_BITS-1:0]   threshold;
      mode_type              pack_mode;
      logic [COUNT_BITS-1:0] channel_count;
   } cfg_type;

   typedef struct packed {
      logic step;
      logic emit;
   } pack_status_type;

   typedef struct packed {
      logic first_bit;
      logic second_bit;
   } code_type;

endpackage

/* rtl/ttbp_csr.sv */
// apb-style configuration registers: threshold, pack mode and channel count
// depends on ttbp_pkg
module ttbp_csr (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [ttbp_pkg::ADDR_BITS-1:0]  csr_paddr,
   input  logic [ttbp_pkg::DATA_BITS-1:0]  csr_pwdata,
   output logic [ttbp_pkg::DATA_BITS-1:0]  csr_prdata,
   output logic                            csr_pready,
   output ttbp_pkg::cfg_type               cfg
);
   import ttbp_pkg::*;

   cfg_type       cfg_ff, cfg_in;
   reg_index_type index;
   logic          write_en;

   assign index      = reg_index_type'(csr_paddr[3:2]);
   assign csr_pready = 1'b1;
   assign write_en   = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      cfg_in = cfg_ff;
      if (write_en) begin
         unique case (index)
            REG_THRESHOLD:     cfg_in.threshold     = csr_pwdata[THR_BITS-1:0];
            REG_PACK_MODE:     cfg_in.pack_mode     = mode_type'(csr_pwdata[MODE_BITS-1:0]);
            REG_CHANNEL_COUNT: cfg_in.channel_count = csr_pwdata[COUNT_BITS-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.threshold     <= '0;
         cfg_ff.pack_mode     <= MODE_SIGN_MAG;
         cfg_ff.channel_count <= COUNT_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   always_comb begin
      csr_prdata = '0;
      unique case (index)
         REG_THRESHOLD:     csr_prdata = DATA_BITS'(cfg_ff.threshold);
         REG_PACK_MODE:     csr_prdata = DATA_BITS'(cfg_ff.pack_mode);
         REG_CHANNEL_COUNT: csr_prdata = DATA_BITS'(cfg_ff.channel_count);
         default:           csr_prdata = '0;
      endcase
   end

   assign cfg = cfg_ff;

endmodule

/* rtl/ttbp_quant.sv */
// threshold quantizer: codes one sample into its two plane bits by mode
// depends on ttbp_pkg
module ttbp_quant (
   input  logic signed [ttbp_pkg::SAMPLE_BITS-1:0] sample,
   input  logic [ttbp_pkg::THR_BITS-1:0]           threshold,
   input  ttbp_pkg::mode_type                      pack_mode,
   output ttbp_pkg::code_type                      code
);
   import ttbp_pkg::*;

   logic signed [SAMPLE_BITS:0] s_ext;
   logic signed [SAMPLE_BITS:0] t_pos;
   logic signed [SAMPLE_BITS:0] t_neg;
   logic                        above;
   logic                        below_neg;
   logic                        below;

   // only the low SAMPLE_BITS-1 threshold bits count
   assign s_ext     = (SAMPLE_BITS+1)'(sample);
   assign t_pos     = $signed({2'b00, threshold[SAMPLE_BITS-2:0]});
   assign t_neg     = -t_pos;
   assign above     = s_ext > t_pos;
   assign below_neg = s_ext < t_neg;
   assign below     = s_ext < t_pos;

   always_comb begin
      code = '0;
      unique case (pack_mode)
         MODE_SIGN_MAG: begin
            code.first_bit  = !above && below_neg;
            code.second_bit = above || below_neg;
         end
         MODE_SIGN_ZERO: begin
            code.first_bit  = !above && below_neg;
            code.second_bit = !above && !below_neg;
         end
         default: begin
            code.first_bit  = below;
            code.second_bit = 1'b0;
         end
      endcase
   end

endmodule

/* rtl/ttbp_packer.sv */
// bitplane accumulators, position and channel counters, result register
// depends on ttbp_pkg and ttbp_quant
module ttbp_packer (
   input  logic                                    clock,
   input  logic                                    reset,
   input  ttbp_pkg::cfg_type                       cfg,
   input  logic                                    in_valid,
   input  logic signed [ttbp_pkg::SAMPLE_BITS-1:0] in_sample,
   output ttbp_pkg::pack_status_type               status,
   output logic                                    out_valid,
   input  logic                                    out_ready,
   output logic [ttbp_pkg::WORD_BITS-1:0]          out_first,
   output logic [ttbp_pkg::WORD_BITS-1:0]          out_second,
   output logic                                    out_done
);
   import ttbp_pkg::*;

   logic [WORD_BITS-1:0]  first_accum_ff, first_accum_in;
   logic [WORD_BITS-1:0]  second_accum_ff, second_accum_in;
   logic [POS_BITS-1:0]   bit_position_ff, bit_position_in;
   logic [INDEX_BITS-1:0] channel_index_ff, channel_index_in;
   logic                  out_valid_ff, out_valid_in;
   logic [WORD_BITS-1:0]  out_first_ff, out_first_in;
   logic [WORD_BITS-1:0]  out_second_ff, out_second_in;
   logic                  out_done_ff, out_done_in;

   code_type              code;
   logic [COUNT_BITS-1:0] eff_count;
   logic [COUNT_BITS-1:0] next_index;
   logic                  last;
   logic                  full;
   logic                  emit;
   logic                  step;
   logic [WORD_BITS-1:0]  bit_sel;
   logic [WORD_BITS-1:0]  pad_mask;
   logic [WORD_BITS-1:0]  first_new;
   logic [WORD_BITS-1:0]  second_new;

   ttbp_quant u_quant (
      .sample    (in_sample),
      .threshold (cfg.threshold),
      .pack_mode (cfg.pack_mode),
      .code      (code)
   );

   always_comb begin
      eff_count = cfg.channel_count;
      if (cfg.channel_count == '0) begin
         eff_count = COUNT_BITS'(1);
      end else if (cfg.channel_count > COUNT_MAX) begin
         eff_count = COUNT_MAX;
      end
   end

   assign next_index = COUNT_BITS'(channel_index_ff) + COUNT_BITS'(1);
   assign last       = next_index >= eff_count;
   assign full       = bit_position_ff == POS_BITS'(WORD_BITS-1);
   assign emit       = last || full;
   assign step       = in_valid && (!emit || !out_valid_ff || out_ready);

   assign bit_sel    = WORD_BITS'(1) << bit_position_ff;
   // positions above the current one, for sign/zero padding of a short word
   assign pad_mask   = {WORD_BITS{1'b1}} << ((POS_BITS+1)'(bit_position_ff) + (POS_BITS+1)'(1));
   assign first_new  = first_accum_ff | (code.first_bit ? bit_sel : '0);
   assign second_new = second_accum_ff | (code.second_bit ? bit_sel : '0);

   always_comb begin
      first_accum_in   = first_accum_ff;
      second_accum_in  = second_accum_ff;
      bit_position_in  = bit_position_ff;
      channel_index_in = channel_index_ff;
      out_valid_in     = out_valid_ff && !out_ready;
      out_first_in     = out_first_ff;
      out_second_in    = out_second_ff;
      out_done_in      = out_done_ff;
      if (step) begin
         if (!emit) begin
            first_accum_in   = first_new;
            second_accum_in  = second_new;
            bit_position_in  = bit_position_ff + POS_BITS'(1);
            channel_index_in = channel_index_ff + INDEX_BITS'(1);
         end else begin
            out_valid_in     = 1'b1;
            out_first_in     = first_new;
            out_second_in    = second_new;
            if (last && !full && cfg.pack_mode == MODE_SIGN_ZERO) begin
               out_second_in = second_new | pad_mask;
            end
            out_done_in      = last;
            first_accum_in   = '0;
            second_accum_in  = '0;
            bit_position_in  = '0;
            channel_index_in = last ? '0 : channel_index_ff + INDEX_BITS'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         first_accum_ff   <= '0;
         second_accum_ff  <= '0;
         bit_position_ff  <= '0;
         channel_index_ff <= '0;
         out_valid_ff     <= 1'b0;
      end else begin
         first_accum_ff   <= first_accum_in;
         second_accum_ff  <= second_accum_in;
         bit_position_ff  <= bit_position_in;
         channel_index_ff <= channel_index_in;
         out_valid_ff     <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_first_ff  <= out_first_in;
      out_second_ff <= out_second_in;
      out_done_ff   <= out_done_in;
   end

   assign status.step = step;
   assign status.emit = emit;
   assign out_valid   = out_valid_ff;
   assign out_first   = out_first_ff;
   assign out_second  = out_second_ff;
   assign out_done    = out_done_ff;

endmodule

/* rtl/ternary_threshold_bit_packer.sv */
// flow: an accepted sample is held in the input register until the packer steps on it; a word
//   pair that it completes is registered in the result register and shown on rsp
// throughput: one sample per cycle, set by the single accumulate stage behind the
//   input register; a stalled result register holds only samples that complete a word
// reset: synchronous active high; clears accumulators, counters and valids,
//   threshold 0, mode sign/magnitude, channel count 64
module ternary_threshold_bit_packer (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_tvalid,
   output logic                                   req_tready,
   input  logic [15:0]                            req_tdata,   // sample
   output logic                                   rsp_tvalid,
   input  logic                                   rsp_tready,
   output logic [127:0]                           rsp_tdata,   // second_plane, first_plane
   output logic                                   rsp_tlast,   // pixel_done
   input  logic                                   csr_psel,
   input  logic                                   csr_penable,
   input  logic                                   csr_pwrite,
   input  logic [ttbp_pkg::ADDR_BITS-1:0]         csr_paddr,
   input  logic [ttbp_pkg::DATA_BITS-1:0]         csr_pwdata,
   output logic [ttbp_pkg::DATA_BITS-1:0]         csr_prdata,
   output logic                                   csr_pready
);
   import ttbp_pkg::*;

   cfg_type                        cfg;
   pack_status_type                status;
   logic                           in_valid_ff, in_valid_in;
   logic signed [SAMPLE_BITS-1:0]  sample_ff, sample_in;
   logic                           req_take;
   logic [WORD_BITS-1:0]           first_plane;
   logic [WORD_BITS-1:0]           second_plane;

   ttbp_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   ttbp_packer u_packer (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .in_valid   (in_valid_ff),
      .in_sample  (sample_ff),
      .status     (status),
      .out_valid  (rsp_tvalid),
      .out_ready  (rsp_tready),
      .out_first  (first_plane),
      .out_second (second_plane),
      .out_done   (rsp_tlast)
   );

   assign req_tready = !in_valid_ff || status.step;
   assign req_take   = req_tvalid && req_tready;

   always_comb begin
      in_valid_in = in_valid_ff && !status.step;
      sample_in   = sample_ff;
      if (req_take) begin
         in_valid_in = 1'b1;
         sample_in   = $signed(req_tdata[SAMPLE_BITS-1:0]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      sample_ff <= sample_in;
   end

   assign rsp_tdata = {second_plane, first_plane};

   a_emit_shows: assert property (@(posedge clock) disable iff (reset)
      status.step && status.emit |=> rsp_tvalid)
      else $error("completed word pair not shown on rsp");

   a_take_loads: assert property (@(posedge clock) disable iff (reset)
      req_take |=> in_valid_ff)
      else $error("accepted word not held in input register");

   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !status.step |=> in_valid_ff && $stable(sample_ff))
      else $error("stalled sample lost or changed");

   a_step_needs_word: assert property (@(posedge clock) disable iff (reset)
      status.step |-> in_valid_ff)
      else $error("packer stepped without a sample");

endmodule
